FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// When the antecedent holds, the consequent must hold at the same edge.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// When the antecedent holds, the consequent must hold at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: rtl/imp_pkg.sv
// ----------------------------------------------------------------------------
// Instruction mix profiler package
// Shared types, decode constants and counter helpers.
// ----------------------------------------------------------------------------
package imp_pkg;

	localparam int COUNT_WIDTH = 32;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam int NUM_CLASS = 9;
	localparam int NUM_REGS = 32;

	typedef logic [COUNT_WIDTH-1:0] count_t;

	// Class counter slots.
	localparam logic [3:0] IDX_TOTAL = 4'd0;
	localparam logic [3:0] IDX_R     = 4'd1;
	localparam logic [3:0] IDX_I     = 4'd2;
	localparam logic [3:0] IDX_J     = 4'd3;
	localparam logic [3:0] IDX_FWD   = 4'd4;
	localparam logic [3:0] IDX_BKW   = 4'd5;
	localparam logic [3:0] IDX_NOT   = 4'd6;
	localparam logic [3:0] IDX_LOAD  = 4'd7;
	localparam logic [3:0] IDX_STORE = 4'd8;

	// Counter index map seen on the read command.
	localparam logic [6:0] CLASS_END  = 7'd9;
	localparam logic [6:0] READ_BASE  = 7'd9;
	localparam logic [6:0] WRITE_BASE = 7'd41;
	localparam logic [6:0] INDEX_END  = 7'd73;

	// Command codes carried in tuser.
	localparam logic CMD_RECORD = 1'b0;
	localparam logic CMD_READ   = 1'b1;

	// Opcodes and function codes.
	localparam logic [5:0] OP_SPECIAL = 6'h00;
	localparam logic [5:0] OP_J       = 6'h02;
	localparam logic [5:0] OP_JAL     = 6'h03;
	localparam logic [5:0] OP_BEQ     = 6'h04;
	localparam logic [5:0] OP_BNE     = 6'h05;
	localparam logic [5:0] OP_LUI     = 6'h0f;
	localparam logic [5:0] OP_LW      = 6'h23;
	localparam logic [5:0] OP_LBU     = 6'h24;
	localparam logic [5:0] OP_LHU     = 6'h25;
	localparam logic [5:0] OP_SB      = 6'h28;
	localparam logic [5:0] OP_SH      = 6'h29;
	localparam logic [5:0] OP_SW      = 6'h2b;
	localparam logic [5:0] FN_SLL     = 6'h00;
	localparam logic [5:0] FN_SRL     = 6'h02;
	localparam logic [5:0] FN_JR      = 6'h08;
	localparam logic [4:0] REG_RA     = 5'd31;

	// One decoded command as it travels from front to back.
	typedef struct packed {
		logic                 is_read;
		logic [6:0]           index;
		logic [NUM_CLASS-1:0] class_inc;
		logic                 rd_a_en;
		logic [4:0]           rd_a;
		logic                 rd_b_en;
		logic [4:0]           rd_b;
		logic                 wr_en;
		logic [4:0]           wr;
	} op_t;

	typedef struct packed {
		logic              empty;
		logic              full;
		logic [QCNT_W-1:0] count;
	} q_status_t;

	// Saturating add of 0, 1 or 2.
	function automatic count_t sat_add(count_t v, logic [1:0] inc);
		logic [COUNT_WIDTH:0] s;
		s = {1'b0, v} + {{(COUNT_WIDTH-1){1'b0}}, inc};
		if (s[COUNT_WIDTH]) begin
			return '1;
		end
		return s[COUNT_WIDTH-1:0];
	endfunction

	// A counter wider than the read port answers all ones once it no longer fits.
	function automatic logic [31:0] clip32(count_t v);
		logic [63:0] w;
		w = 64'(v);
		if (w[63:32] != 32'd0) begin
			return 32'hFFFF_FFFF;
		end
		return w[31:0];
	endfunction

endpackage

FILE: rtl/imp_front.sv
// ----------------------------------------------------------------------------
// Profiler front end
// Accepts commands and decodes trace records into counter increments.
// ----------------------------------------------------------------------------
module imp_front
	import imp_pkg::*;
(
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [103:0] s_tdata,
	input  logic         s_tuser,
	input  q_status_t    q_status,
	output logic         push,
	output op_t          push_op
);

	logic [31:0] pc;
	logic [31:0] word;
	logic [31:0] next_pc;
	logic [31:0] seq_pc;
	logic [5:0]  opcode;
	logic [5:0]  funct;
	logic [4:0]  rs;
	logic [4:0]  rt;
	logic [4:0]  rd;
	logic        is_fwd;
	logic        is_seq;

	assign pc      = s_tdata[31:0];
	assign word    = s_tdata[63:32];
	assign next_pc = s_tdata[95:64];
	assign opcode  = word[31:26];
	assign rs      = word[25:21];
	assign rt      = word[20:16];
	assign rd      = word[15:11];
	assign funct   = word[5:0];
	assign seq_pc  = pc + 32'd4;
	assign is_fwd  = next_pc > seq_pc;
	assign is_seq  = next_pc == seq_pc;

	assign s_tready = !q_status.full;
	assign push     = s_tvalid && s_tready;

	always_comb begin
		push_op           = '0;
		push_op.is_read   = s_tuser == CMD_READ;
		push_op.index     = s_tdata[102:96];
		push_op.rd_a      = rs;
		push_op.rd_b      = rt;
		push_op.wr        = rt;
		if (s_tuser == CMD_RECORD) begin
			push_op.class_inc[IDX_TOTAL] = 1'b1;
			priority if (opcode == OP_SPECIAL) begin
				push_op.class_inc[IDX_R] = 1'b1;
				push_op.wr = rd;
				priority if (funct == FN_JR) begin
					push_op.rd_a_en = 1'b1;
				end else if (funct == FN_SLL || funct == FN_SRL) begin
					push_op.rd_b_en = 1'b1;
					push_op.wr_en   = 1'b1;
				end else begin
					push_op.rd_a_en = 1'b1;
					push_op.rd_b_en = 1'b1;
					push_op.wr_en   = 1'b1;
				end
			end else if (opcode == OP_J || opcode == OP_JAL) begin
				push_op.class_inc[IDX_J] = 1'b1;
				push_op.class_inc[is_fwd ? IDX_FWD : IDX_BKW] = 1'b1;
				push_op.wr    = REG_RA;
				push_op.wr_en = opcode == OP_JAL;
			end else begin
				push_op.class_inc[IDX_I] = 1'b1;
				priority if (opcode == OP_LUI) begin
					push_op.wr_en = 1'b1;
				end else if (opcode == OP_BEQ || opcode == OP_BNE) begin
					push_op.rd_a_en = 1'b1;
					push_op.rd_b_en = 1'b1;
					if (is_seq) begin
						push_op.class_inc[IDX_NOT] = 1'b1;
					end else begin
						push_op.class_inc[is_fwd ? IDX_FWD : IDX_BKW] = 1'b1;
					end
				end else if (opcode == OP_SB || opcode == OP_SH || opcode == OP_SW) begin
					push_op.rd_a_en = 1'b1;
					push_op.rd_b_en = 1'b1;
					push_op.class_inc[IDX_STORE] = 1'b1;
				end else begin
					push_op.class_inc[IDX_LOAD] =
						opcode == OP_LW || opcode == OP_LBU || opcode == OP_LHU;
					push_op.rd_a_en = 1'b1;
					push_op.wr_en   = 1'b1;
				end
			end
		end
	end

endmodule

FILE: rtl/imp_queue.sv
// ----------------------------------------------------------------------------
// Profiler command queue
// Short FIFO of decoded commands between the front and back ends.
// ----------------------------------------------------------------------------
module imp_queue
	import imp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  op_t       push_op,
	input  logic      pop,
	output op_t       head,
	output q_status_t status
);

	op_t               mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign head         = mem_q[rd_ptr_q];
	assign status.count = count_q;
	assign status.empty = count_q == '0;
	assign status.full  = count_q == QCNT_W'(QUEUE_DEPTH);

	function automatic logic [QPTR_W-1:0] ptr_next(logic [QPTR_W-1:0] p);
		if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/imp_back.sv
// ----------------------------------------------------------------------------
// Profiler back end
// Applies counter increments and answers counter reads through an output register.
// ----------------------------------------------------------------------------
module imp_back
	import imp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  op_t         head,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata
);

	count_t      class_q [NUM_CLASS];
	count_t      rreg_q  [NUM_REGS];
	count_t      wreg_q  [NUM_REGS];
	logic [1:0]  rd_inc  [NUM_REGS];
	logic        out_valid_q;
	logic [31:0] out_data_q;
	count_t      sel_value;
	logic        do_update;

	// A read waits only while an earlier answer is still held and not taken.
	assign pop       = head_valid && (!head.is_read || !out_valid_q || m_tready);
	assign do_update = pop && !head.is_read;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;

	// A register named as both rs and rt is read twice.
	always_comb begin
		for (int i = 0; i < NUM_REGS; i++) begin
			rd_inc[i] = {1'b0, head.rd_a_en && head.rd_a == 5'(i)} +
				{1'b0, head.rd_b_en && head.rd_b == 5'(i)};
		end
	end

	always_comb begin
		priority if (head.index < CLASS_END) begin
			sel_value = class_q[head.index[3:0]];
		end else if (head.index < WRITE_BASE) begin
			sel_value = rreg_q[5'(head.index - READ_BASE)];
		end else if (head.index < INDEX_END) begin
			sel_value = wreg_q[5'(head.index - WRITE_BASE)];
		end else begin
			sel_value = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CLASS; i++) begin
				class_q[i] <= '0;
			end
			for (int i = 0; i < NUM_REGS; i++) begin
				rreg_q[i] <= '0;
				wreg_q[i] <= '0;
			end
		end else if (do_update) begin
			for (int i = 0; i < NUM_CLASS; i++) begin
				class_q[i] <= sat_add(class_q[i], {1'b0, head.class_inc[i]});
			end
			for (int i = 0; i < NUM_REGS; i++) begin
				rreg_q[i] <= sat_add(rreg_q[i], rd_inc[i]);
				wreg_q[i] <= sat_add(wreg_q[i], {1'b0, head.wr_en && head.wr == 5'(i)});
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && head.is_read) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.is_read) begin
			out_data_q <= clip32(sel_value);
		end
	end

endmodule

FILE: rtl/instruction_mix_profiler.sv
// ----------------------------------------------------------------------------
// Instruction mix profiler
// Counts instruction formats, branch and jump outcomes, loads, stores and
// per-register reads and writes over a trace of retired MIPS instructions.
// ----------------------------------------------------------------------------
// The slave channel takes one request per cycle while s_tready is high. tuser selects the command:
// a record request carries pc, instruction and next_pc and gives no answer;
// a read request carries counter_index and gives one answer on the master
// channel with the selected counter, saturated at all ones.
// A request accepted on the slave channel is decoded and queued; the back end
// takes it from the queue head and registers a read answer in the output
// register. Sustained throughput is one request per cycle while no read waits
// for m_tready, set by the single counter update the back end performs each cycle.
// The two-entry queue decouples the sides: while an answer waits for
// m_tready, records keep draining, and a further read waits in the queue;
// s_tready drops only when the queue is full.
// Reset clears every counter and the queue at once; no clearing pass runs.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module instruction_mix_profiler
	import imp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// pc [31:0], instruction [63:32], next_pc [95:64], counter_index [102:96], zero [103]
	input  logic [103:0] s_tdata,
	// command [0]
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// read_data [31:0]
	output logic [31:0]  m_tdata
);

	logic      push;
	op_t       push_op;
	op_t       head;
	q_status_t q_status;
	logic      pop;

	imp_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_status (q_status),
		.push     (push),
		.push_op  (push_op)
	);

	imp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.head    (head),
		.status  (q_status)
	);

	imp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (!q_status.empty),
		.head       (head),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

	`ASSERT_ALWAYS(a_queue_bound, clk, arst_n, q_status.count <= QCNT_W'(QUEUE_DEPTH), "queue count above depth")
	`ASSERT_NEXT(a_push_lands, clk, arst_n, s_tvalid && s_tready, q_status.count != '0, "accepted request missing from queue")
	`ASSERT_SAME(a_read_no_clobber, clk, arst_n, pop && head.is_read, !m_tvalid || m_tready, "read answer overwrote a held answer")
	`ASSERT_SAME(a_answer_source, clk, arst_n, $rose(m_tvalid), $past(pop && head.is_read), "answer without a read request")

endmodule

FILE: sim/instruction_mix_profiler_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Instruction mix profiler checker
// Watches both stream channels, keeps an independent set of counters updated
// from every accepted record request, and compares each counter answer with
// the value predicted when its read request was accepted.
// ----------------------------------------------------------------------------
module instruction_mix_profiler_checker
	import imp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	// pc [31:0], instruction [63:32], next_pc [95:64], counter_index [102:96], zero [103]
	input  logic [103:0] s_tdata,
	// command [0]
	input  logic         s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	// read_data [31:0]
	input  logic [31:0]  m_tdata,
	input  logic         end_of_test,
	output int unsigned  error_count,
	output int unsigned  pending_reads
);

	count_t      class_tally [NUM_CLASS];
	count_t      reads_per_reg [NUM_REGS];
	count_t      writes_per_reg [NUM_REGS];
	logic [31:0] answer_queue [$];
	logic [31:0] expected_value;
	bit          leftovers_checked;

	initial begin
		error_count = 0;
		pending_reads = 0;
		leftovers_checked = 1'b0;
	end

	task automatic flag_mismatch(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		error_count++;
	endtask

	function automatic count_t bumped(count_t v);
		return (v == '1) ? v : v + count_t'(1);
	endfunction

	task automatic count_class(input logic [3:0] slot);
		class_tally[slot] = bumped(class_tally[slot]);
	endtask

	task automatic count_read(input logic [4:0] r);
		reads_per_reg[r] = bumped(reads_per_reg[r]);
	endtask

	task automatic count_write(input logic [4:0] r);
		writes_per_reg[r] = bumped(writes_per_reg[r]);
	endtask

	// Applies one retired instruction to the predicted counters.
	task automatic tally_instruction(input logic [31:0] pc, input logic [31:0] word,
			input logic [31:0] next_pc);
		logic [5:0]  opcode;
		logic [5:0]  funct;
		logic [4:0]  rs;
		logic [4:0]  rt;
		logic [4:0]  rd;
		logic [31:0] seq_pc;
		opcode = word[31:26];
		rs     = word[25:21];
		rt     = word[20:16];
		rd     = word[15:11];
		funct  = word[5:0];
		// The fall-through address wraps at the top of the address space.
		seq_pc = pc + 32'd4;
		count_class(IDX_TOTAL);
		if (opcode == OP_SPECIAL) begin
			count_class(IDX_R);
			if (funct == FN_JR) begin
				count_read(rs);
			end else if (funct == FN_SLL || funct == FN_SRL) begin
				count_read(rt);
				count_write(rd);
			end else begin
				count_read(rs);
				count_read(rt);
				count_write(rd);
			end
		end else if (opcode == OP_J || opcode == OP_JAL) begin
			count_class(IDX_J);
			count_class(next_pc > seq_pc ? IDX_FWD : IDX_BKW);
			if (opcode == OP_JAL) begin
				count_write(REG_RA);
			end
		end else begin
			count_class(IDX_I);
			if (opcode == OP_LUI) begin
				count_write(rt);
			end else if (opcode == OP_BEQ || opcode == OP_BNE) begin
				count_read(rs);
				count_read(rt);
				if (next_pc == seq_pc) begin
					count_class(IDX_NOT);
				end else begin
					count_class(next_pc > seq_pc ? IDX_FWD : IDX_BKW);
				end
			end else if (opcode == OP_SB || opcode == OP_SH || opcode == OP_SW) begin
				count_read(rs);
				count_read(rt);
				count_class(IDX_STORE);
			end else begin
				if (opcode == OP_LW || opcode == OP_LBU || opcode == OP_LHU) begin
					count_class(IDX_LOAD);
				end
				count_read(rs);
				count_write(rt);
			end
		end
	endtask

	function automatic logic [31:0] counter_value(input logic [6:0] idx);
		count_t v;
		if (idx < CLASS_END) begin
			v = class_tally[idx[3:0]];
		end else if (idx < WRITE_BASE) begin
			v = reads_per_reg[5'(idx - READ_BASE)];
		end else if (idx < INDEX_END) begin
			v = writes_per_reg[5'(idx - WRITE_BASE)];
		end else begin
			v = '0;
		end
		if (64'(v) > 64'hFFFF_FFFF) begin
			return '1;
		end
		return 32'(v);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CLASS; i++) begin
				class_tally[i] = '0;
			end
			for (int i = 0; i < NUM_REGS; i++) begin
				reads_per_reg[i] = '0;
				writes_per_reg[i] = '0;
			end
			answer_queue.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (answer_queue.size() == 0) begin
					flag_mismatch($sformatf("answer %08h arrived with no read pending",
						m_tdata));
				end else begin
					expected_value = answer_queue.pop_front();
					if (m_tdata !== expected_value) begin
						flag_mismatch($sformatf("read_data %08h, expected %08h",
							m_tdata, expected_value));
					end
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser == CMD_READ) begin
					answer_queue.push_back(counter_value(s_tdata[102:96]));
				end else begin
					tally_instruction(s_tdata[31:0], s_tdata[63:32], s_tdata[95:64]);
				end
			end
			if (end_of_test && !leftovers_checked) begin
				leftovers_checked = 1'b1;
				if (answer_queue.size() != 0) begin
					flag_mismatch($sformatf("%0d counter reads never answered",
						answer_queue.size()));
				end
			end
		end
		pending_reads = answer_queue.size();
	end

endmodule

FILE: sim/instruction_mix_profiler_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Instruction mix profiler testbench
// Drives directed and random record and read requests with random idle
// bursts on both channels; a checker beside the block predicts every
// counter answer and counts mismatches.
// ----------------------------------------------------------------------------
module instruction_mix_profiler_test;
	import imp_pkg::*;

	localparam logic [5:0] OP_ADDI   = 6'h08;
	localparam logic [5:0] OP_UNUSED = 6'h3f;
	localparam logic [5:0] FN_ADD    = 6'h20;
	localparam int         RANDOM_REQUESTS = 650;
	localparam int         CALM_FROM = 560;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [103:0] s_tdata;
	logic         s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [31:0]  m_tdata;
	logic         end_of_test;
	int unsigned  error_count;
	int unsigned  pending_reads;
	bit           quiet_tail;

	instruction_mix_profiler u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	instruction_mix_profiler_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.end_of_test   (end_of_test),
		.error_count   (error_count),
		.pending_reads (pending_reads)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// Receiver side: random stall bursts, none once the run has calmed down.
	initial begin
		m_tready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!quiet_tail && $urandom_range(3, 0) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(4, 1)) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(8, 1)) @(posedge clk);
		end
	end

	function automatic logic [31:0] make_word(input logic [5:0] op, input logic [4:0] rs,
			input logic [4:0] rt, input logic [4:0] rd, input logic [5:0] fn);
		return {op, rs, rt, rd, 5'd0, fn};
	endfunction

	// Holds one request on the slave channel until it is accepted.
	task automatic send_request(input logic cmd, input logic [31:0] pc,
			input logic [31:0] word, input logic [31:0] next_pc, input logic [6:0] idx);
		int gap;
		if (!quiet_tail && $urandom_range(3, 0) == 0) begin
			gap = $urandom_range(4, 1);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {1'b0, idx, next_pc, word, pc};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic record_instr(input logic [31:0] pc, input logic [31:0] word,
			input logic [31:0] next_pc);
		send_request(CMD_RECORD, pc, word, next_pc, 7'($urandom));
	endtask

	task automatic read_counter(input logic [6:0] idx);
		send_request(CMD_READ, $urandom, $urandom, $urandom, idx);
	endtask

	task automatic random_record();
		logic [31:0] word;
		logic [31:0] pc;
		logic [31:0] next_pc;
		word = $urandom;
		case ($urandom_range(15, 0))
			0, 1:    word[31:26] = OP_SPECIAL;
			2:       word[31:26] = OP_J;
			3:       word[31:26] = OP_JAL;
			4:       word[31:26] = OP_BEQ;
			5:       word[31:26] = OP_BNE;
			6:       word[31:26] = OP_LUI;
			7:       word[31:26] = OP_LW;
			8:       word[31:26] = OP_LBU;
			9:       word[31:26] = OP_LHU;
			10:      word[31:26] = OP_SB;
			11:      word[31:26] = OP_SH;
			12:      word[31:26] = OP_SW;
			default: word[31:26] = 6'($urandom);
		endcase
		if (word[31:26] == OP_SPECIAL) begin
			case ($urandom_range(4, 0))
				0:       word[5:0] = FN_JR;
				1:       word[5:0] = FN_SLL;
				2:       word[5:0] = FN_SRL;
				default: word[5:0] = 6'($urandom);
			endcase
		end
		case ($urandom_range(9, 0))
			0, 1, 2, 3: pc = $urandom;
			4:          pc = 32'hFFFF_FFF0 + 32'($urandom_range(15, 0));
			default:    pc = {14'd0, 16'($urandom), 2'b00};
		endcase
		case ($urandom_range(9, 0))
			0, 1, 2, 3: next_pc = pc + 32'd4;
			4, 5, 6:    next_pc = pc + 32'd4 + 32'($urandom_range(4096, 1));
			7, 8:       next_pc = pc + 32'd4 - 32'($urandom_range(4096, 1));
			default:    next_pc = $urandom;
		endcase
		record_instr(pc, word, next_pc);
	endtask

	initial begin
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = CMD_RECORD;
		end_of_test = 1'b0;
		quiet_tail  = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reads of untouched counters, then one of each instruction shape.
		read_counter(7'd0);
		read_counter(7'd72);
		record_instr(32'h0040_0000, make_word(OP_SPECIAL, 5'd1, 5'd2, 5'd3, FN_ADD),
			32'h0040_0004);
		record_instr(32'h0040_0004, make_word(OP_SPECIAL, 5'd31, 5'd0, 5'd0, FN_JR),
			32'h0040_1000);
		record_instr(32'h0040_0008, make_word(OP_SPECIAL, 5'd9, 5'd4, 5'd5, FN_SLL),
			32'h0040_000C);
		record_instr(32'h0040_000C, make_word(OP_SPECIAL, 5'd9, 5'd6, 5'd7, FN_SRL),
			32'h0040_0010);
		record_instr(32'h0040_0010, make_word(OP_J, 5'd0, 5'd0, 5'd0, 6'd0), 32'h0040_0100);
		// A jump to the fall-through address counts as backward.
		record_instr(32'h0040_0100, make_word(OP_J, 5'd0, 5'd0, 5'd0, 6'd0), 32'h0040_0104);
		record_instr(32'h0040_0104, make_word(OP_JAL, 5'd0, 5'd0, 5'd0, 6'd0), 32'h0040_0000);
		record_instr(32'h0040_0200, make_word(OP_BEQ, 5'd8, 5'd8, 5'd0, 6'd0), 32'h0040_0204);
		record_instr(32'h0040_0204, make_word(OP_BEQ, 5'd8, 5'd9, 5'd0, 6'd0), 32'h0040_0300);
		record_instr(32'h0040_0300, make_word(OP_BNE, 5'd10, 5'd11, 5'd0, 6'd0), 32'h0040_0000);
		record_instr(32'h0040_0304, make_word(OP_LUI, 5'd0, 5'd12, 5'd0, 6'd0), 32'h0040_0308);
		record_instr(32'h0040_0308, make_word(OP_LW, 5'd29, 5'd13, 5'd0, 6'd0), 32'h0040_030C);
		record_instr(32'h0040_030C, make_word(OP_LBU, 5'd29, 5'd14, 5'd0, 6'd0), 32'h0040_0310);
		record_instr(32'h0040_0310, make_word(OP_LHU, 5'd29, 5'd15, 5'd0, 6'd0), 32'h0040_0314);
		record_instr(32'h0040_0314, make_word(OP_SB, 5'd29, 5'd16, 5'd0, 6'd0), 32'h0040_0318);
		record_instr(32'h0040_0318, make_word(OP_SH, 5'd29, 5'd17, 5'd0, 6'd0), 32'h0040_031C);
		record_instr(32'h0040_031C, make_word(OP_SW, 5'd29, 5'd18, 5'd0, 6'd0), 32'h0040_0320);
		// Register zero is counted like any other register.
		record_instr(32'h0040_0320, make_word(OP_ADDI, 5'd0, 5'd0, 5'd0, 6'd0), 32'h0040_0324);
		// The fall-through address of the last word wraps to zero.
		record_instr(32'hFFFF_FFFC, make_word(OP_BNE, 5'd1, 5'd2, 5'd0, 6'd0), 32'h0000_0000);
		record_instr(32'hFFFF_FFFC, make_word(OP_J, 5'd0, 5'd0, 5'd0, 6'd0), 32'h0000_0010);
		record_instr(32'hFFFF_FFFC, {OP_UNUSED, 26'h3FF_FFFF}, 32'hFFFF_FFFF);
		read_counter(7'd72);
		read_counter(INDEX_END);
		read_counter(7'd127);

		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n == CALM_FROM) begin
				quiet_tail = 1'b1;
			end
			if ($urandom_range(9, 0) < 3) begin
				if ($urandom_range(6, 0) == 0) begin
					read_counter(7'($urandom_range(127, 73)));
				end else begin
					read_counter(7'($urandom_range(72, 0)));
				end
			end else begin
				random_record();
			end
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_reads != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
		end_of_test <= 1'b1;
		repeat (2) @(posedge clk);
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
